>>> rtl/srtf_pkg.sv
// Shared types and constants for the shortest-remaining-time-first tick scheduler.
`default_nettype none

package srtf_pkg;

    localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic        command;
        logic [3:0]  slot;
        logic [7:0]  process_tag;
        logic [15:0] arrival;
        logic [15:0] burst;
    } t_in_item;

    typedef struct packed {
        logic [23:0] current_time;
        logic        idle;
        logic [7:0]  running_tag;
        logic        completed;
        logic [23:0] completed_wait;
        logic        all_done;
    } t_out_item;

    // Best candidate so far as it travels along the chain of slot cells.
    typedef struct packed {
        logic        found;
        logic        work;
        logic [15:0] rem;
        logic [15:0] arr;
        logic [7:0]  tag;
        logic [23:0] wait_cnt;
    } t_cand;

    // Controls broadcast from the sequencer to every slot cell.
    typedef struct packed {
        logic        load;
        logic        update;
        logic        found;
        logic [7:0]  tag;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [23:0] now;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/srtf_ifs.sv
// Valid/ready channel interfaces for scheduler commands and tick reports.
`default_nettype none

interface srtf_in_if import srtf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface srtf_out_if import srtf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/srtf_tick_scheduler_core.sv
// Top level of the shortest-remaining-time-first tick scheduler.
//
//   Port   | Dir | Payload     | Transfer
//   -------+-----+-------------+---------------------------------------
//   i_in   | in  | t_in_item   | load or tick command, valid && ready
//   o_out  | out | t_out_item  | one report per tick, valid && ready
//
// A load is written into its slot while idle. After a tick's transfer the
// best candidate moves through the chain of slot cells one cell per cycle, then all
// cells update together and the report register is loaded in that same update.
// The next command is accepted only after the update, when the scheduler is idle again.
// Reset clears every slot, the tick counter and the report valid flag.
// A report waits in its register until taken; loads are still accepted then,
// and a following tick holds in its update cycle until the register is free.
`default_nettype none

module srtf_tick_scheduler_core import srtf_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    srtf_in_if.sink   i_in,
    srtf_out_if.source o_out
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_cnt;
    logic [23:0]      r_time;
    logic             r_out_valid;
    t_out_item        r_out;

    t_cell_ctl        ctl;
    t_cand            w_cand [NUM_SLOTS+1];
    logic [IDX_W-1:0] w_idx  [NUM_SLOTS+1];
    t_cand            fin;
    logic             in_xfer;
    logic             do_update;
    logic             fin_done;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign do_update  = (r_state == ST_UPDATE) && (!r_out_valid || o_out.ready);

    assign ctl.load    = in_xfer && (i_in.payload.command == CMD_LOAD);
    assign ctl.update  = do_update;
    assign ctl.found   = fin.found;
    assign ctl.tag     = i_in.payload.process_tag;
    assign ctl.arrival = i_in.payload.arrival;
    assign ctl.burst   = i_in.payload.burst;
    assign ctl.now     = r_time;

    assign w_cand[0] = '0;
    assign w_idx[0]  = '0;

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        srtf_cell #(
            .IDX_W(IDX_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_load_sel(32'(i_in.payload.slot) == 32'(k)),
            .i_index   (IDX_W'(k)),
            .i_win_idx (w_idx[NUM_SLOTS]),
            .i_cand    (w_cand[k]),
            .i_cand_idx(w_idx[k]),
            .o_cand    (w_cand[k+1]),
            .o_cand_idx(w_idx[k+1])
        );
    end

    assign fin      = w_cand[NUM_SLOTS];
    assign fin_done = fin.found && (fin.rem == 16'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_time      <= 24'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_update) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer && (i_in.payload.command == CMD_TICK)) begin
                        r_state <= ST_SCAN;
                        r_cnt   <= '0;
                    end
                end
                ST_SCAN: begin
                    if (r_cnt == IDX_W'(NUM_SLOTS - 1)) begin
                        r_state <= ST_UPDATE;
                    end else begin
                        r_cnt <= r_cnt + IDX_W'(1);
                    end
                end
                ST_UPDATE: begin
                    if (do_update) begin
                        r_state                  <= ST_IDLE;
                        r_out.current_time       <= r_time;
                        r_out.idle               <= !fin.found;
                        r_out.running_tag        <= fin.found ? fin.tag : 8'd0;
                        r_out.completed          <= fin_done;
                        r_out.completed_wait     <= fin_done ? fin.wait_cnt : 24'd0;
                        r_out.all_done           <= !fin.work && (!fin.found || fin_done);
                        if (r_time != COUNT_MAX) begin
                            r_time <= r_time + 24'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    a_report_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state) == ST_UPDATE)
        else $error("report appeared without an update cycle");

    a_idle_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.idle) |->
        (o_out.payload.running_tag == 8'd0 && !o_out.payload.completed))
        else $error("idle report carries a running process");

    a_wait_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.payload.completed_wait <= o_out.payload.current_time)
        else $error("waiting count exceeds elapsed ticks");

endmodule

`default_nettype wire

>>> rtl/srtf_cell.sv
// One process slot cell that holds its state and forwards the best candidate.
`default_nettype none

module srtf_cell import srtf_pkg::*; #(
    parameter int IDX_W = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic             i_load_sel,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire logic [IDX_W-1:0] i_win_idx,
    input  wire t_cand            i_cand,
    input  wire logic [IDX_W-1:0] i_cand_idx,
    output t_cand                 o_cand,
    output logic [IDX_W-1:0]      o_cand_idx
);

    logic        r_valid;
    logic [7:0]  r_tag;
    logic [15:0] r_arr;
    logic [15:0] r_rem;
    logic [23:0] r_wait;
    t_cand       r_cand;
    logic [IDX_W-1:0] r_cand_idx;

    t_cand            n_cand;
    logic [IDX_W-1:0] n_cand_idx;
    logic             has_work;
    logic             ready;
    logic             better;

    assign has_work = r_valid && (r_rem != 16'd0);
    assign ready    = has_work && ({8'd0, r_arr} <= i_ctl.now);
    assign better   = ready && (!i_cand.found || (r_rem < i_cand.rem) ||
                      ((r_rem == i_cand.rem) && (r_arr < i_cand.arr)));

    always_comb begin
        if (better) begin
            n_cand.found    = 1'b1;
            n_cand.work     = i_cand.work | i_cand.found;
            n_cand.rem      = r_rem;
            n_cand.arr      = r_arr;
            n_cand.tag      = r_tag;
            n_cand.wait_cnt = r_wait;
            n_cand_idx      = i_index;
        end else begin
            n_cand      = i_cand;
            n_cand.work = i_cand.work | has_work;
            n_cand_idx  = i_cand_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand     <= n_cand;
        r_cand_idx <= n_cand_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rem   <= 16'd0;
            r_wait  <= 24'd0;
        end else if (i_ctl.load && i_load_sel) begin
            r_valid <= (i_ctl.burst != 16'd0);
            r_tag   <= i_ctl.tag;
            r_arr   <= i_ctl.arrival;
            r_rem   <= i_ctl.burst;
            r_wait  <= 24'd0;
        end else if (i_ctl.update) begin
            if (i_ctl.found && (i_win_idx == i_index)) begin
                r_rem <= r_rem - 16'd1;
            end else if (ready && (r_wait != COUNT_MAX)) begin
                r_wait <= r_wait + 24'd1;
            end
        end
    end

    assign o_cand     = r_cand;
    assign o_cand_idx = r_cand_idx;

endmodule

`default_nettype wire

>>> bench/srtf_sched_checker.sv
// Scoreboard for the scheduler: mirrors slot state from command transfers and checks each report.
`timescale 1ns / 1ps

module srtf_sched_checker import srtf_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srtf_in_if   i_cmd_mon,
    srtf_out_if  i_rpt_mon,
    output int   o_fail_count,
    output int   o_pending
);

    logic        loaded    [NUM_SLOTS];
    logic [7:0]  tag_of    [NUM_SLOTS];
    logic [15:0] arrive_at [NUM_SLOTS];
    logic [15:0] work_left [NUM_SLOTS];
    logic [23:0] waited    [NUM_SLOTS];
    logic [23:0] sched_time;

    t_out_item report_q[$];
    t_out_item want;
    t_out_item got;
    t_in_item  cmd;
    int        mismatches = 0;

    function automatic void apply_load(input t_in_item c);
        if (c.slot < NUM_SLOTS) begin
            tag_of[c.slot]    = c.process_tag;
            arrive_at[c.slot] = c.arrival;
            work_left[c.slot] = c.burst;
            waited[c.slot]    = '0;
            loaded[c.slot]    = (c.burst != 16'd0);
        end
    endfunction

    function automatic t_out_item schedule_tick();
        t_out_item r;
        int        best;
        logic      found;
        logic      rdy [NUM_SLOTS];
        r     = '0;
        best  = 0;
        found = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            rdy[i] = loaded[i] && (work_left[i] != 16'd0) && ({8'h00, arrive_at[i]} <= sched_time);
            if (rdy[i] && (!found || work_left[i] < work_left[best] ||
                    (work_left[i] == work_left[best] && arrive_at[i] < arrive_at[best]))) begin
                best  = i;
                found = 1'b1;
            end
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (rdy[i] && (!found || i != best) && waited[i] < COUNT_MAX) begin
                waited[i] = waited[i] + 24'd1;
            end
        end
        r.current_time = sched_time;
        r.idle         = !found;
        if (found) begin
            r.running_tag   = tag_of[best];
            work_left[best] = work_left[best] - 16'd1;
            if (work_left[best] == 16'd0) begin
                r.completed      = 1'b1;
                r.completed_wait = waited[best];
            end
        end
        r.all_done = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (loaded[i] && work_left[i] != 16'd0) begin
                r.all_done = 1'b0;
            end
        end
        if (sched_time < COUNT_MAX) begin
            sched_time = sched_time + 24'd1;
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [23:0] exp_v,
                                 input logic [23:0] act_v, input logic [23:0] at_tick);
        if (exp_v !== act_v) begin
            if (mismatches < 10) begin
                $display("Mismatch in %s at tick %0d: expected %0h, got %0h",
                         name, at_tick, exp_v, act_v);
            end
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                loaded[i]    = 1'b0;
                tag_of[i]    = '0;
                arrive_at[i] = '0;
                work_left[i] = '0;
                waited[i]    = '0;
            end
            sched_time = '0;
            report_q.delete();
        end else begin
            if (i_rpt_mon.valid && i_rpt_mon.ready) begin
                got = i_rpt_mon.payload;
                if (report_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("Unexpected report transfer: %0h", got);
                    end
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    compare_field("current_time", want.current_time, got.current_time,
                                  want.current_time);
                    compare_field("idle", 24'(want.idle), 24'(got.idle), want.current_time);
                    compare_field("running_tag", 24'(want.running_tag),
                                  24'(got.running_tag), want.current_time);
                    compare_field("completed", 24'(want.completed), 24'(got.completed),
                                  want.current_time);
                    compare_field("completed_wait", want.completed_wait, got.completed_wait,
                                  want.current_time);
                    compare_field("all_done", 24'(want.all_done), 24'(got.all_done),
                                  want.current_time);
                end
            end
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                cmd = i_cmd_mon.payload;
                if (cmd.command == CMD_TICK) begin
                    report_q = {report_q, schedule_tick()};
                end else begin
                    apply_load(cmd);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= report_q.size();
    end

endmodule

>>> bench/tb_srtf_tick_scheduler_core.sv
// Top of the scheduler testbench: clock, reset, command stimulus, report back-pressure and verdict.
`timescale 1ns / 1ps

module tb_srtf_tick_scheduler_core;
    import srtf_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int ITEM_TARGET  = 450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   items_sent  = 0;
    int   ticks_sent  = 0;
    int   burst_left  = 0;

    always #1 i_clk = ~i_clk;

    srtf_in_if  cmd_ch ();
    srtf_out_if rpt_ch ();

    srtf_tick_scheduler_core #(.NUM_SLOTS(NUM_SLOTS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (rpt_ch)
    );

    srtf_sched_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_mon    (cmd_ch),
        .i_rpt_mon    (rpt_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_item load_cmd(input logic [3:0] slot, input logic [7:0] tag,
                                          input logic [15:0] arr, input logic [15:0] burst);
        t_in_item c;
        c.command     = CMD_LOAD;
        c.slot        = slot;
        c.process_tag = tag;
        c.arrival     = arr;
        c.burst       = burst;
        return c;
    endfunction

    function automatic t_in_item tick_cmd();
        t_in_item    c;
        logic [63:0] r;
        r         = {$urandom, $urandom};
        c         = r[44:0];
        c.command = CMD_TICK;
        return c;
    endfunction

    task automatic send_command(input t_in_item item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                cmd_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= item;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
        if (item.command == CMD_TICK) begin
            ticks_sent++;
        end
    endtask

    task automatic run_job_batch(input logic cut_short);
        int       jobs;
        int       span;
        int       max_off;
        int       off;
        int       b;
        int       n_ticks;
        t_in_item c;
        jobs    = $urandom_range(1, 5);
        span    = 0;
        max_off = 0;
        for (int k = 0; k < jobs; k++) begin
            off = $urandom_range(0, 6);
            b   = $urandom_range(1, 6);
            send_command(load_cmd(4'($urandom_range(0, 15)), 8'($urandom),
                                  16'(ticks_sent + off), 16'(b)));
            span += b;
            if (off > max_off) begin
                max_off = off;
            end
        end
        n_ticks = cut_short ? $urandom_range(0, span) : span + max_off + $urandom_range(0, 2);
        repeat (n_ticks) begin
            if ($urandom_range(0, 9) == 0) begin
                c = load_cmd(4'($urandom_range(0, 15)), 8'($urandom),
                             16'(ticks_sent + $urandom_range(0, 3)), 16'($urandom_range(0, 4)));
                send_command(c);
            end
            send_command(tick_cmd());
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The report side stalls in changing patterns and twice holds off for a long stretch.
    initial begin
        int rx_cycle;
        int hold_left;
        int mode;
        int mode_left;
        rx_cycle     = 0;
        hold_left    = 0;
        mode         = 0;
        mode_left    = 0;
        rpt_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle == 2000 || rx_cycle == 6000) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rpt_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0: begin
                        rpt_ch.ready <= 1'b1;
                    end
                    1: begin
                        rpt_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        rpt_ch.ready <= ($urandom_range(0, 5) == 0);
                    end
                endcase
            end
        end
    end

    initial begin
        int          sel;
        logic [63:0] r;
        t_in_item    noise;
        i_rst_n        = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_command(tick_cmd());
        send_command(load_cmd(4'd15, 8'hA5, 16'd0, 16'd2));
        send_command(load_cmd(4'd3, 8'h5A, 16'd0, 16'd2));
        send_command(tick_cmd());
        send_command(tick_cmd());
        send_command(load_cmd(4'd7, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_command(load_cmd(4'd0, 8'h00, 16'd3, 16'd2));
        send_command(tick_cmd());
        send_command(tick_cmd());
        send_command(load_cmd(4'd1, 8'h11, 16'd0, 16'd2));
        send_command(tick_cmd());
        send_command(load_cmd(4'd1, 8'h22, 16'd0, 16'd5));
        send_command(tick_cmd());
        send_command(load_cmd(4'd0, 8'h33, 16'd0, 16'd0));
        send_command(tick_cmd());
        send_command(load_cmd(4'd1, 8'h44, 16'd0, 16'd0));
        send_command(tick_cmd());
        send_command(load_cmd(4'd7, 8'h55, 16'd0, 16'd0));
        send_command(tick_cmd());

        while (items_sent < ITEM_TARGET) begin
            sel = $urandom_range(0, 9);
            if (sel <= 5) begin
                run_job_batch(1'b0);
            end else if (sel == 6) begin
                run_job_batch(1'b1);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    r     = {$urandom, $urandom};
                    noise = r[44:0];
                    send_command(noise);
                end
            end
        end
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> srtf_tick_scheduler_core.f
rtl/srtf_pkg.sv
rtl/srtf_ifs.sv
rtl/srtf_cell.sv
rtl/srtf_tick_scheduler_core.sv
bench/srtf_sched_checker.sv
bench/tb_srtf_tick_scheduler_core.sv
